FILE: rtl/core/tha_pkg.sv
// Package of shared types, constants and the CORDIC angle table for the tilt and heading averager.
package tha_pkg;

   localparam int WindowDepthDefault = 8;
   localparam int CordicStepsDefault = 16;
   localparam int TableLen = 24;

   localparam int RawWidth = 16;
   localparam int ElevWidth = 14;
   localparam int AzimWidth = 16;
   localparam int AngleWidth = 34;
   localparam int VecWidth = 44;
   localparam int SqWidth = 50;
   localparam int RootWidth = 25;

   localparam logic signed [AngleWidth-1:0] HalfTurnFx = 34'sd1179648000;
   localparam logic signed [AngleWidth-1:0] HalfLsb = 34'sd32768;
   localparam logic signed [15:0] DeclMax = 16'sd18000;
   localparam logic signed [15:0] DeclMin = -16'sd18000;
   localparam logic [17:0] FullTurn = 18'd36000;
   localparam logic [13:0] ElevMax = 14'd9000;

   localparam logic [0:0] RegDeclination = 1'b0;

   // One classified item as it travels through the queue.
   typedef struct packed {
      logic signed [RawWidth-1:0] accel_x;
      logic signed [RawWidth-1:0] accel_y;
      logic signed [RawWidth-1:0] accel_z;
      logic                       accel_valid;
      logic signed [RawWidth-1:0] mag_x;
      logic signed [RawWidth-1:0] mag_y;
      logic                       mag_valid;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQRT,
      ST_ELEV_INIT,
      ST_ELEV_ROT,
      ST_AZIM_INIT,
      ST_AZIM_ROT,
      ST_WINDOW,
      ST_DIVIDE,
      ST_OUTPUT
   } back_state_type;

   // atan(2^-i) in hundredths of a degree times 65536.
   function automatic logic signed [AngleWidth-1:0] atan_entry(input logic [4:0] idx);
      logic signed [AngleWidth-1:0] v;
      case (idx)
         5'd0: v = 34'sd294912000;
         5'd1: v = 34'sd174096719;
         5'd2: v = 34'sd91987925;
         5'd3: v = 34'sd46694507;
         5'd4: v = 34'sd23437865;
         5'd5: v = 34'sd11730358;
         5'd6: v = 34'sd5866610;
         5'd7: v = 34'sd2933484;
         5'd8: v = 34'sd1466764;
         5'd9: v = 34'sd733385;
         5'd10: v = 34'sd366693;
         5'd11: v = 34'sd183346;
         5'd12: v = 34'sd91673;
         5'd13: v = 34'sd45837;
         5'd14: v = 34'sd22918;
         5'd15: v = 34'sd11459;
         5'd16: v = 34'sd5730;
         5'd17: v = 34'sd2865;
         5'd18: v = 34'sd1432;
         5'd19: v = 34'sd716;
         5'd20: v = 34'sd358;
         5'd21: v = 34'sd179;
         5'd22: v = 34'sd90;
         5'd23: v = 34'sd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/tha_front.sv
// Front part: takes input items and the declination register, and feeds a two-entry queue.
module tha_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tha_pkg::item_type     req_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [1:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic signed [15:0]    decl,
   output logic                  q_valid,
   input  logic                  q_take,
   output tha_pkg::item_type     q_item
);
   import tha_pkg::*;

   logic signed [15:0] decl_ff, decl_in, wr_val;
   item_type           slot_ff [2];
   logic               rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;

   // Saturate the written declination into range.
   assign wr_val = $signed(csr_pwdata[15:0]);
   always_comb begin
      decl_in = decl_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1] == RegDeclination) begin
         if (wr_val > DeclMax) begin
            decl_in = DeclMax;
         end else if (wr_val < DeclMin) begin
            decl_in = DeclMin;
         end else begin
            decl_in = wr_val;
         end
      end
   end
   assign csr_prdata = (csr_paddr[1] == RegDeclination) ? {{16{decl_ff[15]}}, decl_ff} : '0;
   assign decl = decl_ff;

   // Queue bookkeeping.
   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_take ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         decl_ff <= decl_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end
endmodule

FILE: rtl/core/tha_back.sv
// Back part: square root, shared CORDIC, rolling windows and averaging divide.
module tha_back #(
   parameter int WINDOW_DEPTH = tha_pkg::WindowDepthDefault,
   parameter int CORDIC_STEPS = tha_pkg::CordicStepsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  tha_pkg::item_type     q_item,
   input  logic signed [15:0]    decl,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [13:0]           rsp_elevation_avg,
   output logic [15:0]           rsp_azimuth_avg
);
   import tha_pkg::*;

   localparam int SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CntW = $clog2(WINDOW_DEPTH + 1);
   localparam int ESumW = ElevWidth + CntW;
   localparam int ASumW = AzimWidth + CntW;
   localparam int DivSteps = ASumW;
   localparam int DivCntW = $clog2(DivSteps + 1);

   back_state_type state_ff, state_in;
   item_type       it_ff;

   logic [SqWidth-1:0]   sq_ff;
   logic [SqWidth-1:0]   root_ff;
   logic [SqWidth-1:0]   bit_ff;
   logic [5:0]           step_ff;

   logic signed [VecWidth-1:0]   x_ff, y_ff;
   logic signed [AngleWidth-1:0] z_ff;
   logic                         zero_vec_ff;
   logic [13:0]                  elev_ff;
   logic [15:0]                  azim_ff;

   logic [ElevWidth-1:0] ewin_ff [WINDOW_DEPTH];
   logic [AzimWidth-1:0] awin_ff [WINDOW_DEPTH];
   logic [ESumW-1:0]     esum_ff;
   logic [ASumW-1:0]     asum_ff;
   logic [SlotW-1:0]     slot_ff;
   logic [CntW-1:0]      fill_ff;

   logic [ASumW-1:0]  eq_ff, aq_ff;
   logic [CntW:0]     er_ff, ar_ff;
   logic [DivCntW-1:0] dcnt_ff;

   logic signed [AngleWidth-1:0] z_rnd;
   logic signed [AngleWidth-1:0] ang;
   logic signed [VecWidth-1:0]   ax_ext;
   logic signed [VecWidth-1:0]   dx, dy;
   logic signed [17:0]           head;
   logic [CntW:0]                er_sh, ar_sh;
   logic [CntW-1:0]              fill_new;

   // Rounded CORDIC angle in hundredths of a degree; a zero vector gives zero.
   assign z_rnd = (z_ff + HalfLsb) >>> 16;
   assign ang = zero_vec_ff ? '0 : z_rnd;
   assign ax_ext = VecWidth'(it_ff.accel_x);
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign head = 18'(ang) + 18'(decl);
   assign fill_new = (fill_ff < CntW'(WINDOW_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
   assign er_sh = {er_ff[CntW-1:0], eq_ff[ASumW-1]};
   assign ar_sh = {ar_ff[CntW-1:0], aq_ff[ASumW-1]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_SQRT;
         ST_SQRT: if (bit_ff == '0) state_in = ST_ELEV_INIT;
         ST_ELEV_INIT: state_in = ST_ELEV_ROT;
         ST_ELEV_ROT: if (step_ff == 6'(CORDIC_STEPS)) state_in = ST_AZIM_INIT;
         ST_AZIM_INIT: state_in = ST_AZIM_ROT;
         ST_AZIM_ROT: if (step_ff == 6'(CORDIC_STEPS)) state_in = ST_WINDOW;
         ST_WINDOW: state_in = ST_DIVIDE;
         ST_DIVIDE: if (dcnt_ff == DivCntW'(DivSteps)) state_in = ST_OUTPUT;
         ST_OUTPUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      q_take = (state_ff == ST_IDLE) && q_valid;
      rsp_valid = (state_ff == ST_OUTPUT);
   end
   assign rsp_elevation_avg = eq_ff[13:0];
   assign rsp_azimuth_avg = aq_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff <= '0;
         fill_ff <= '0;
         esum_ff <= '0;
         asum_ff <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            ewin_ff[i] <= '0;
            awin_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WINDOW) begin
            ewin_ff[slot_ff] <= elev_ff;
            awin_ff[slot_ff] <= azim_ff;
            esum_ff <= esum_ff - ESumW'(ewin_ff[slot_ff]) + ESumW'(elev_ff);
            asum_ff <= asum_ff - ASumW'(awin_ff[slot_ff]) + ASumW'(azim_ff);
            slot_ff <= (slot_ff == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            fill_ff <= fill_new;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            it_ff <= q_item;
            sq_ff <= (SqWidth'(q_item.accel_y * q_item.accel_y)
                      + SqWidth'(q_item.accel_z * q_item.accel_z)) << 16;
            root_ff <= '0;
            bit_ff <= SqWidth'(1) << 48;
         end
         ST_SQRT: begin
            // One result bit per cycle, operand scaled by 65536.
            if (bit_ff != '0) begin
               if (sq_ff >= root_ff + bit_ff) begin
                  sq_ff <= sq_ff - root_ff - bit_ff;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_ELEV_INIT || state_ff == ST_AZIM_INIT) begin
         logic signed [VecWidth-1:0] xi, yi;
         xi = (state_ff == ST_ELEV_INIT) ? VecWidth'(root_ff[RootWidth-1:0])
                                         : VecWidth'(it_ff.mag_x) <<< 8;
         yi = (state_ff == ST_ELEV_INIT) ? -(ax_ext <<< 8) : VecWidth'(it_ff.mag_y) <<< 8;
         step_ff <= '0;
         zero_vec_ff <= (xi == 0) && (yi == 0);
         if (xi < 0) begin
            z_ff <= (yi >= 0) ? HalfTurnFx : -HalfTurnFx;
            x_ff <= -xi;
            y_ff <= -yi;
         end else begin
            z_ff <= '0;
            x_ff <= xi;
            y_ff <= yi;
         end
      end
      if ((state_ff == ST_ELEV_ROT || state_ff == ST_AZIM_ROT)
          && step_ff != 6'(CORDIC_STEPS)) begin
         step_ff <= step_ff + 1'b1;
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_entry(step_ff[4:0]);
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_entry(step_ff[4:0]);
         end
      end
      if (state_ff == ST_ELEV_ROT && step_ff == 6'(CORDIC_STEPS)) begin
         if (!it_ff.accel_valid || it_ff.accel_x >= 0 || ang < 0) elev_ff <= '0;
         else if (ang > 34'(ElevMax)) elev_ff <= ElevMax;
         else elev_ff <= ang[13:0];
      end
      if (state_ff == ST_AZIM_ROT && step_ff == 6'(CORDIC_STEPS)) begin
         if (!it_ff.mag_valid) azim_ff <= '0;
         else if (head < 0) azim_ff <= 16'(head + 18'(FullTurn));
         else if (head >= 18'(FullTurn)) azim_ff <= 16'(head - 18'(FullTurn));
         else azim_ff <= head[15:0];
      end
      if (state_ff == ST_WINDOW) begin
         eq_ff <= ASumW'(esum_ff - ESumW'(ewin_ff[slot_ff]) + ESumW'(elev_ff));
         aq_ff <= asum_ff - ASumW'(awin_ff[slot_ff]) + ASumW'(azim_ff);
         er_ff <= '0;
         ar_ff <= '0;
         dcnt_ff <= '0;
      end
      // Restoring divide by the fill count, one quotient bit a cycle.
      if (state_ff == ST_DIVIDE && dcnt_ff != DivCntW'(DivSteps)) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (er_sh >= {1'b0, fill_ff}) begin
            er_ff <= er_sh - {1'b0, fill_ff};
            eq_ff <= {eq_ff[ASumW-2:0], 1'b1};
         end else begin
            er_ff <= er_sh;
            eq_ff <= {eq_ff[ASumW-2:0], 1'b0};
         end
         if (ar_sh >= {1'b0, fill_ff}) begin
            ar_ff <= ar_sh - {1'b0, fill_ff};
            aq_ff <= {aq_ff[ASumW-2:0], 1'b1};
         end else begin
            ar_ff <= ar_sh;
            aq_ff <= {aq_ff[ASumW-2:0], 1'b0};
         end
      end
   end
endmodule

FILE: rtl/core/tilt_heading_averager.sv
// Top level of the tilt and heading averager.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | accel x/y/z, accel_valid, mag x/y, mag_valid
//  rsp     | out       | rsp_valid/stall    | elevation_avg, azimuth_avg
//  csr     | in        | APB psel/penable   | declination at address 0
//
// An item is taken from the queue, then passes a bit-serial square root, two CORDIC passes
// of CORDIC_STEPS rotations each, one window update, a bit-serial divide and a result state
// that holds while rsp_stall is high.
// A two-entry queue takes items while the back part is busy, until the queue is full.
// Reset clears the windows, sums, fill count and declination at once.
module tilt_heading_averager #(
   parameter int WINDOW_DEPTH = tha_pkg::WindowDepthDefault,
   parameter int CORDIC_STEPS = tha_pkg::CordicStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [15:0]  req_accel_x,
   input  logic [15:0]  req_accel_y,
   input  logic [15:0]  req_accel_z,
   input  logic         req_accel_valid,
   input  logic [15:0]  req_mag_x,
   input  logic [15:0]  req_mag_y,
   input  logic         req_mag_valid,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [13:0]  rsp_elevation_avg,
   output logic [15:0]  rsp_azimuth_avg,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import tha_pkg::*;

   item_type           req_item, q_item;
   logic               q_valid, q_take;
   logic signed [15:0] decl;

   assign pready = 1'b1;
   assign req_item = '{accel_x: req_accel_x, accel_y: req_accel_y, accel_z: req_accel_z,
                       accel_valid: req_accel_valid, mag_x: req_mag_x, mag_y: req_mag_y,
                       mag_valid: req_mag_valid};

   tha_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .decl(decl), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   tha_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item), .decl(decl),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_elevation_avg(rsp_elevation_avg), .rsp_azimuth_avg(rsp_azimuth_avg)
   );
endmodule
